### hdl/ecov_pkg.sv
// Shared types and constants for the edge coverage hit counter.
// Holds the transfer payload structs, operation codes and configuration indexes.
// No dependencies.
package ecov_pkg;

    localparam int unsigned ADDR_W    = 64;
    localparam int unsigned EDGE_ID_W = 16;
    localparam int unsigned COUNT_W   = 8;
    localparam int unsigned OP_W      = 2;
    localparam int unsigned CFG_IDX_W = 2;

    typedef logic [OP_W-1:0]      t_op;
    typedef logic [CFG_IDX_W-1:0] t_cfg_index;

    localparam t_op OP_RECORD = 2'd0;
    localparam t_op OP_READ   = 2'd1;
    localparam t_op OP_CLEAR  = 2'd2;

    localparam t_cfg_index CFG_RANGE_LOW   = 2'd0;
    localparam t_cfg_index CFG_RANGE_HIGH  = 2'd1;
    localparam t_cfg_index CFG_EXIT_OFFSET = 2'd2;

    typedef struct packed {
        t_op                  operation;
        logic [ADDR_W-1:0]    branch_address;
        logic [EDGE_ID_W-1:0] entry_index;
    } t_in_item;

    typedef struct packed {
        logic               recorded;
        logic [COUNT_W-1:0] counter_value;
        logic               exit_hit;
    } t_out_item;

    typedef struct packed {
        logic [ADDR_W-1:0] range_low;
        logic [ADDR_W-1:0] range_high;
        logic [ADDR_W-1:0] exit_offset;
    } t_cfg_regs;

endpackage

### hdl/ecov_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No package dependencies.
module ecov_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/ecov_cfg.sv
// Configuration register file: range bounds and exit offset.
// Depends on ecov_pkg for the register struct and index codes.
module ecov_cfg (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  ecov_pkg::t_cfg_index  i_cfg_index,
    input  logic [63:0]           i_cfg_data,
    output ecov_pkg::t_cfg_regs   o_regs
);
    import ecov_pkg::*;

    t_cfg_regs r_regs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_RANGE_LOW:   r_regs.range_low   <= i_cfg_data;
                CFG_RANGE_HIGH:  r_regs.range_high  <= i_cfg_data;
                CFG_EXIT_OFFSET: r_regs.exit_offset <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_regs      = r_regs;

endmodule

### hdl/edge_coverage_hit_counter_unit.sv
// Top level of the edge coverage hit counter: sequencer, counter RAM and result register.
// Depends on ecov_pkg, ecov_cfg and ecov_ram.
//
// The block keeps a map of MAP_ENTRIES 8-bit hit counters in one synchronous RAM and
// handles one item at a time. An item is accepted in the idle state, then passes
// through an evaluate state for the 64-bit range compare and offset subtraction, a
// read state issuing the RAM read, and a write state updating the counter and loading
// the result register; a new item is taken only once the last one has left the write
// state, since the registered RAM read and the dependency on the previous edge id require it.
// A result waiting in the output register does not block acceptance; the write state
// waits only while the previous result is still there and not being taken. After
// reset the block sweeps the RAM to zero, one entry per cycle, and accepts no item
// until the sweep is done; configuration writes are taken at any time. MAP_ENTRIES
// must be a power of two. Record items whose address lies outside the inclusive range,
// and unused operation codes, return an all-zero result and change nothing.
module edge_coverage_hit_counter_unit #(
    parameter int unsigned MAP_ENTRIES = 65536
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  ecov_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output ecov_pkg::t_out_item  o_out_item,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  ecov_pkg::t_cfg_index i_cfg_index,
    input  logic [63:0]          i_cfg_data
);
    import ecov_pkg::*;

    localparam int unsigned AW = $clog2(MAP_ENTRIES);
    // Only this many edge id bits can select an entry.
    localparam int unsigned IW = (AW < EDGE_ID_W) ? AW : EDGE_ID_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL,
        S_READ,
        S_WRITE
    } t_state;

    t_state               r_state;
    t_in_item             r_item;
    logic                 r_in_range;
    logic [ADDR_W-1:0]    r_offset;
    logic                 r_hit;
    logic [AW-1:0]        r_idx;
    logic [AW-1:0]        r_clr_addr;
    logic [EDGE_ID_W-1:0] r_prev;
    logic                 r_out_valid;
    t_out_item            r_out_item;

    t_cfg_regs            cfg;
    logic [AW-1:0]        rd_addr;
    logic [COUNT_W-1:0]   rd_data;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [COUNT_W-1:0]   ram_wdata;
    logic                 advance;
    logic                 is_clear;
    logic                 upd_we;
    logic [COUNT_W-1:0]   upd_value;
    logic [EDGE_ID_W-1:0] edge_id;

    ecov_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_regs      (cfg)
    );

    // Record items index by the XOR of the new offset with the previous one; read and
    // clear items use the entry index given with the item.
    assign edge_id = r_offset[EDGE_ID_W-1:0] ^ r_prev;
    always_comb begin
        if (r_item.operation == OP_RECORD) begin
            rd_addr = AW'(edge_id[IW-1:0]);
        end else begin
            rd_addr = AW'(r_item.entry_index[IW-1:0]);
        end
    end

    // The update cycle can finish once the result register is free or being drained.
    assign advance  = (r_state == S_WRITE) && (!r_out_valid || i_out_ready);
    assign is_clear = (r_item.operation == OP_CLEAR);

    always_comb begin
        upd_we    = 1'b0;
        upd_value = '0;
        if (r_in_range) begin
            upd_we    = 1'b1;
            upd_value = rd_data + COUNT_W'(1);
        end else if (is_clear) begin
            upd_we    = 1'b1;
        end
    end

    // The clearing sweep owns the write port until it is done.
    always_comb begin
        if (r_state == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else begin
            ram_we    = advance && upd_we;
            ram_waddr = r_idx;
            ram_wdata = upd_value;
        end
    end

    ecov_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (MAP_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_prev      <= '0;
            r_out_valid <= 1'b0;
            r_in_range  <= 1'b0;
            r_hit       <= 1'b0;
        end else begin
            // A drained result frees the register unless a new one is loaded now.
            if (r_out_valid && i_out_ready && !advance) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_item  <= i_in_item;
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_in_range <= (r_item.operation == OP_RECORD)
                                  && (r_item.branch_address >= cfg.range_low)
                                  && (r_item.branch_address <= cfg.range_high);
                    r_offset   <= r_item.branch_address - cfg.range_low;
                    r_state    <= S_READ;
                end
                S_READ: begin
                    r_idx   <= rd_addr;
                    r_hit   <= r_in_range && (cfg.exit_offset != '0)
                               && (cfg.exit_offset == r_offset);
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    if (advance) begin
                        r_out_valid              <= 1'b1;
                        r_out_item.recorded      <= r_in_range;
                        r_out_item.exit_hit      <= r_hit;
                        if (r_in_range) begin
                            r_out_item.counter_value <= upd_value;
                            r_prev                   <= r_offset[EDGE_ID_W-1:0];
                        end else if (is_clear || r_item.operation == OP_READ) begin
                            r_out_item.counter_value <= rd_data;
                        end else begin
                            r_out_item.counter_value <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef NO_ASSERTIONS
    // No item may be taken while the counter RAM is still being swept.
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_in_ready)
        else $error("item accepted during the clearing sweep");

    // Finishing an update always leaves a result in the output register.
    a_result_follows_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_out_valid)
        else $error("update finished without a result");

    // An exit hit is only reported for a counted record.
    a_hit_needs_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.exit_hit) |-> o_out_item.recorded)
        else $error("exit hit without a recorded branch");

    // The previous edge id only moves when an in-range record completes.
    a_prev_moves_on_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_prev) |-> ($past(advance) && $past(r_in_range)))
        else $error("previous edge id changed outside a record update");

    // An update never overwrites a result that has not been transferred.
    a_no_result_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_out_valid) |-> i_out_ready)
        else $error("result register overwritten before transfer");
`endif

endmodule
